[rtl/trfsm_pkg.sv]
// Shared types, codes and constants of the thermal recovery state machine.
`timescale 1ns / 1ps
`default_nettype none

package trfsm_pkg;

    localparam int TEMP_W   = 13;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDXW = 3;

    // Item commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Encoded state as reported in a result word.
    localparam logic [1:0] STATE_HOT       = 2'd0;
    localparam logic [1:0] STATE_COOLING   = 2'd1;
    localparam logic [1:0] STATE_STAB      = 2'd2;
    localparam logic [1:0] STATE_RECOVERED = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [REG_IDXW-1:0] REG_HOT_THRESHOLD  = 3'd0;
    localparam logic [REG_IDXW-1:0] REG_COOL_THRESHOLD = 3'd1;
    localparam logic [REG_IDXW-1:0] REG_REC_THRESHOLD  = 3'd2;
    localparam logic [REG_IDXW-1:0] REG_DWELL_MS       = 3'd3;
    localparam logic [REG_IDXW-1:0] REG_INIT_TPUT      = 3'd4;
    localparam logic [REG_IDXW-1:0] REG_OSC_LIMIT      = 3'd5;

    // Register reset values.
    localparam logic signed [TEMP_W-1:0] RST_HOT_THRESHOLD  = 13'sd656;
    localparam logic signed [TEMP_W-1:0] RST_COOL_THRESHOLD = 13'sd608;
    localparam logic signed [TEMP_W-1:0] RST_REC_THRESHOLD  = 13'sd560;
    localparam logic [15:0]              RST_DWELL_MS       = 16'd5000;
    localparam logic [11:0]              RST_INIT_TPUT      = 12'd240;
    localparam logic [7:0]               RST_OSC_LIMIT      = 8'd3;

    // Throughput factors in Q8 and pacing delays in ms.
    localparam logic [8:0]  FACTOR_HOT       = 9'd77;
    localparam logic [8:0]  FACTOR_COOLING   = 9'd128;
    localparam logic [8:0]  FACTOR_STAB      = 9'd205;
    localparam logic [8:0]  FACTOR_RECOVERED = 9'd256;
    localparam logic [10:0] DELAY_HOT        = 11'd2000;
    localparam logic [10:0] DELAY_COOLING    = 11'd1000;
    localparam logic [10:0] DELAY_STAB       = 11'd200;
    localparam logic [10:0] DELAY_RECOVERED  = 11'd0;

    typedef enum logic [3:0] {
        MODE_HOT       = 4'b0001,
        MODE_COOLING   = 4'b0010,
        MODE_STAB      = 4'b0100,
        MODE_RECOVERED = 4'b1000
    } mode_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] hot_threshold;
        logic signed [TEMP_W-1:0] cool_threshold;
        logic signed [TEMP_W-1:0] recovered_threshold;
        logic [15:0]              dwell_ms;
        logic [11:0]              initial_throughput;
        logic [7:0]               oscillation_limit;
    } cfg_t;

    // Status of one finished item on its way to the result register.
    typedef struct packed {
        logic [1:0]  thermal_state;
        logic [15:0] spike_count;
        logic [15:0] oscillation_count;
        logic        restore_safe;
        logic [15:0] time_in_state_ms;
    } res_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        c = STATE_RECOVERED;
        case (m)
            MODE_HOT:       c = STATE_HOT;
            MODE_COOLING:   c = STATE_COOLING;
            MODE_STAB:      c = STATE_STAB;
            MODE_RECOVERED: c = STATE_RECOVERED;
            default:        c = STATE_RECOVERED;
        endcase
        return c;
    endfunction

    function automatic logic [8:0] state_factor(input logic [1:0] s);
        logic [8:0] f;
        f = FACTOR_RECOVERED;
        case (s)
            STATE_HOT:     f = FACTOR_HOT;
            STATE_COOLING: f = FACTOR_COOLING;
            STATE_STAB:    f = FACTOR_STAB;
            default:       f = FACTOR_RECOVERED;
        endcase
        return f;
    endfunction

    function automatic logic [10:0] state_delay(input logic [1:0] s);
        logic [10:0] d;
        d = DELAY_RECOVERED;
        case (s)
            STATE_HOT:     d = DELAY_HOT;
            STATE_COOLING: d = DELAY_COOLING;
            STATE_STAB:    d = DELAY_STAB;
            default:       d = DELAY_RECOVERED;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/trfsm_in_if.sv]
// Handshake channel that carries input words (sample or tick).
`timescale 1ns / 1ps
`default_nettype none

interface trfsm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [trfsm_pkg::TEMP_W-1:0]   temperature;

    modport source (output valid, output cmd, output temperature, input ready);
    modport sink   (input valid, input cmd, input temperature, output ready);
endinterface

`default_nettype wire

[rtl/trfsm_out_if.sv]
// Handshake channel that carries result words.
`timescale 1ns / 1ps
`default_nettype none

interface trfsm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  thermal_state;
    logic [11:0] throughput;
    logic [10:0] pacing_delay_ms;
    logic [15:0] spike_count;
    logic [15:0] oscillation_count;
    logic        restore_safe;
    logic [15:0] time_in_state_ms;

    modport source (
        output valid, output thermal_state, output throughput, output pacing_delay_ms,
        output spike_count, output oscillation_count, output restore_safe,
        output time_in_state_ms, input ready
    );
    modport sink (
        input valid, input thermal_state, input throughput, input pacing_delay_ms,
        input spike_count, input oscillation_count, input restore_safe,
        input time_in_state_ms, output ready
    );
endinterface

`default_nettype wire

[rtl/trfsm_cfg.sv]
// APB-style configuration register file of the thermal state machine.
`timescale 1ns / 1ps
`default_nettype none

module trfsm_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [trfsm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [trfsm_pkg::APB_DW-1:0]   pwdata,
    output logic      [trfsm_pkg::APB_DW-1:0]   prdata,
    output logic                                pready,
    output trfsm_pkg::cfg_t                     cfg
);

    trfsm_pkg::cfg_t                       cfg_reg;
    logic                                  wr_en;
    logic [trfsm_pkg::REG_IDXW-1:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[trfsm_pkg::APB_AW-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hot_threshold       <= trfsm_pkg::RST_HOT_THRESHOLD;
            cfg_reg.cool_threshold      <= trfsm_pkg::RST_COOL_THRESHOLD;
            cfg_reg.recovered_threshold <= trfsm_pkg::RST_REC_THRESHOLD;
            cfg_reg.dwell_ms            <= trfsm_pkg::RST_DWELL_MS;
            cfg_reg.initial_throughput  <= trfsm_pkg::RST_INIT_TPUT;
            cfg_reg.oscillation_limit   <= trfsm_pkg::RST_OSC_LIMIT;
        end
        else if (wr_en)
        begin
            case (idx)
                trfsm_pkg::REG_HOT_THRESHOLD:  cfg_reg.hot_threshold       <= pwdata[12:0];
                trfsm_pkg::REG_COOL_THRESHOLD: cfg_reg.cool_threshold      <= pwdata[12:0];
                trfsm_pkg::REG_REC_THRESHOLD:  cfg_reg.recovered_threshold <= pwdata[12:0];
                trfsm_pkg::REG_DWELL_MS:       cfg_reg.dwell_ms            <= pwdata[15:0];
                trfsm_pkg::REG_INIT_TPUT:      cfg_reg.initial_throughput  <= pwdata[11:0];
                trfsm_pkg::REG_OSC_LIMIT:      cfg_reg.oscillation_limit   <= pwdata[7:0];
                default:                       ;
            endcase
        end
    end

    // Thresholds read back sign-extended; the others zero-extended.
    always_comb
    begin
        prdata = '0;
        case (idx)
            trfsm_pkg::REG_HOT_THRESHOLD:
                prdata = {{(trfsm_pkg::APB_DW-13){cfg_reg.hot_threshold[12]}},
                          cfg_reg.hot_threshold};
            trfsm_pkg::REG_COOL_THRESHOLD:
                prdata = {{(trfsm_pkg::APB_DW-13){cfg_reg.cool_threshold[12]}},
                          cfg_reg.cool_threshold};
            trfsm_pkg::REG_REC_THRESHOLD:
                prdata = {{(trfsm_pkg::APB_DW-13){cfg_reg.recovered_threshold[12]}},
                          cfg_reg.recovered_threshold};
            trfsm_pkg::REG_DWELL_MS:  prdata = {16'd0, cfg_reg.dwell_ms};
            trfsm_pkg::REG_INIT_TPUT: prdata = {20'd0, cfg_reg.initial_throughput};
            trfsm_pkg::REG_OSC_LIMIT: prdata = {24'd0, cfg_reg.oscillation_limit};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/trfsm_core.sv]
// Input register, mode register, counters and the next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module trfsm_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    trfsm_in_if.sink             in_ch,
    input  trfsm_pkg::cfg_t      cfg,
    output logic                 step_valid,
    input  wire logic            step_ready,
    output trfsm_pkg::res_t      step_res
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                                  s1_valid_reg;
    logic                                  s1_cmd_reg;
    logic signed [trfsm_pkg::TEMP_W-1:0]   s1_temp_reg;
    logic                                  advance;

    trfsm_pkg::mode_t          mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]    dwell_reg, dwell_next;
    logic [COUNT_WIDTH-1:0]    spikes_reg, spikes_next;
    logic [COUNT_WIDTH-1:0]    osc_reg, osc_next;
    logic [15:0]               spikes16, osc16, dwell16;

    assign advance      = s1_valid_reg && step_ready;
    assign in_ch.ready  = !s1_valid_reg || step_ready;
    assign step_valid   = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_cmd_reg  <= in_ch.cmd;
            s1_temp_reg <= in_ch.temperature;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        dwell_next  = dwell_reg;
        spikes_next = spikes_reg;
        osc_next    = osc_reg;
        if (s1_cmd_reg == trfsm_pkg::CMD_TICK)
        begin
            dwell_next = (dwell_reg == CNT_MAX) ? dwell_reg : dwell_reg + COUNT_WIDTH'(1);
        end
        else if (s1_temp_reg > cfg.hot_threshold)
        begin
            if (mode_reg != trfsm_pkg::MODE_HOT)
            begin
                spikes_next = (spikes_reg == CNT_MAX) ? spikes_reg
                                                      : spikes_reg + COUNT_WIDTH'(1);
                if (mode_reg == trfsm_pkg::MODE_COOLING || mode_reg == trfsm_pkg::MODE_STAB)
                begin
                    osc_next = (osc_reg == CNT_MAX) ? osc_reg : osc_reg + COUNT_WIDTH'(1);
                end
                mode_next  = trfsm_pkg::MODE_HOT;
                dwell_next = '0;
            end
        end
        else
        begin
            case (mode_reg)
                trfsm_pkg::MODE_HOT:
                begin
                    // Only a temperature inside the cool..hot band leaves hot.
                    if (s1_temp_reg > cfg.cool_threshold)
                    begin
                        mode_next  = trfsm_pkg::MODE_COOLING;
                        dwell_next = '0;
                    end
                end
                trfsm_pkg::MODE_COOLING:
                begin
                    if (s1_temp_reg <= cfg.cool_threshold)
                    begin
                        mode_next  = trfsm_pkg::MODE_STAB;
                        dwell_next = '0;
                    end
                end
                trfsm_pkg::MODE_STAB:
                begin
                    if (s1_temp_reg <= cfg.recovered_threshold &&
                        CMP_W'(dwell_reg) > CMP_W'(cfg.dwell_ms))
                    begin
                        mode_next  = trfsm_pkg::MODE_RECOVERED;
                        dwell_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= trfsm_pkg::MODE_RECOVERED;
            dwell_reg  <= '0;
            spikes_reg <= '0;
            osc_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            dwell_reg  <= dwell_next;
            spikes_reg <= spikes_next;
            osc_reg    <= osc_next;
        end
    end

    // Counters wider than the result fields are shown saturated.
    generate
        if (COUNT_WIDTH > 16)
        begin : g_sat
            assign spikes16 = (spikes_next > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                                                                     : spikes_next[15:0];
            assign osc16    = (osc_next > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                                                                  : osc_next[15:0];
            assign dwell16  = (dwell_next > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                                                                    : dwell_next[15:0];
        end
        else
        begin : g_ext
            assign spikes16 = 16'(spikes_next);
            assign osc16    = 16'(osc_next);
            assign dwell16  = 16'(dwell_next);
        end
    endgenerate

    always_comb
    begin
        step_res.thermal_state     = trfsm_pkg::mode_code(mode_next);
        step_res.spike_count       = spikes16;
        step_res.oscillation_count = osc16;
        step_res.time_in_state_ms  = dwell16;
        step_res.restore_safe      = (mode_next == trfsm_pkg::MODE_RECOVERED) &&
                                     (CMP_W'(osc_next) < CMP_W'(cfg.oscillation_limit));
    end

endmodule

`default_nettype wire

[rtl/trfsm_result.sv]
// Result register: scales throughput, picks the pacing delay, holds the word.
`timescale 1ns / 1ps
`default_nettype none

module trfsm_result (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_valid,
    output logic                 step_ready,
    input  trfsm_pkg::res_t      step_res,
    input  wire logic [11:0]     initial_throughput,
    trfsm_out_if.source          out_ch
);

    logic             out_valid_reg;
    trfsm_pkg::res_t  res_reg;
    logic [11:0]      tput_reg;
    logic [10:0]      delay_reg;
    logic [19:0]      product;

    assign step_ready = !out_valid_reg || out_ch.ready;
    assign product    = 20'(initial_throughput) *
                        20'(trfsm_pkg::state_factor(step_res.thermal_state));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_ready)
        begin
            out_valid_reg <= step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_valid && step_ready)
        begin
            res_reg   <= step_res;
            tput_reg  <= product[19:8];
            delay_reg <= trfsm_pkg::state_delay(step_res.thermal_state);
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.thermal_state     = res_reg.thermal_state;
    assign out_ch.throughput        = tput_reg;
    assign out_ch.pacing_delay_ms   = delay_reg;
    assign out_ch.spike_count       = res_reg.spike_count;
    assign out_ch.oscillation_count = res_reg.oscillation_count;
    assign out_ch.restore_safe      = res_reg.restore_safe;
    assign out_ch.time_in_state_ms  = res_reg.time_in_state_ms;

endmodule

`default_nettype wire

[rtl/thermal_recovery_fsm_unit.sv]
// Thermal recovery state machine: top level with channels and APB port.
// Path: an accepted word moves from the core's input register to the result
// register, which drives out_ch. Throughput: one word per cycle unless out_ch
// stalls; the only loop is the mode and counter update.
// Reset: rst_n is asynchronous, active low; the mode returns to recovered, the
// counters clear, the registers take their default values and both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module thermal_recovery_fsm_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    trfsm_in_if.sink                            in_ch,
    trfsm_out_if.source                         out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [trfsm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [trfsm_pkg::APB_DW-1:0]   pwdata,
    output logic      [trfsm_pkg::APB_DW-1:0]   prdata,
    output logic                                pready
);

    // The block is a two-stage pipeline. The core holds the accepted word in
    // its input register; the next mode and counters are computed from it and,
    // at the edge at which they update, the result register loads the
    // finished word. Ready propagates back from the output channel so that a
    // new word is taken every cycle as long as the result side keeps up.
    trfsm_pkg::cfg_t  cfg;
    trfsm_pkg::res_t  step_res;
    logic             step_valid;
    logic             step_ready;

    trfsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trfsm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step_res   (step_res)
    );

    // The throughput multiply sits in front of the result register.
    trfsm_result u_result (
        .clk                (clk),
        .rst_n              (rst_n),
        .step_valid         (step_valid),
        .step_ready         (step_ready),
        .step_res           (step_res),
        .initial_throughput (cfg.initial_throughput),
        .out_ch             (out_ch)
    );

    // Restore is only ever reported as safe in the recovered state.
    a_safe_only_recovered: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.restore_safe |->
            out_ch.thermal_state == trfsm_pkg::STATE_RECOVERED)
        else $error("restore_safe outside recovered state");

    // The pacing delay always matches the reported state.
    a_delay_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            (out_ch.thermal_state == trfsm_pkg::STATE_HOT &&
             out_ch.pacing_delay_ms == trfsm_pkg::DELAY_HOT) ||
            (out_ch.thermal_state == trfsm_pkg::STATE_COOLING &&
             out_ch.pacing_delay_ms == trfsm_pkg::DELAY_COOLING) ||
            (out_ch.thermal_state == trfsm_pkg::STATE_STAB &&
             out_ch.pacing_delay_ms == trfsm_pkg::DELAY_STAB) ||
            (out_ch.thermal_state == trfsm_pkg::STATE_RECOVERED &&
             out_ch.pacing_delay_ms == trfsm_pkg::DELAY_RECOVERED))
        else $error("pacing delay does not match state");

    // The input side only stalls while a result word waits to be taken.
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && !in_ch.ready |-> out_ch.valid && !out_ch.ready)
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
